[rtl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define OLAD_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Antecedent this cycle implies consequent in the next cycle.
`define OLAD_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/olad_pkg.sv]
`default_nettype none

package olad_pkg;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;
  localparam logic [1:0] STATUS_FULL  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_DEL_DONE,
    ST_READ
  } state_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] entry_value;
    logic [4:0] entry_index;
    logic [4:0] length;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

[rtl/olad_ram.sv]
`default_nettype none

module olad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/olad_seq.sv]
`default_nettype none

module olad_seq #(
  parameter int CAPACITY = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        req_valid,
  output logic                             req_ready,
  input  wire logic [1:0]                  op,
  input  wire logic [7:0]                  value,
  input  wire logic [7:0]                  position,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output olad_pkg::result_t                res,
  output logic                             ram_we,
  output logic [$clog2(CAPACITY)-1:0]      ram_waddr,
  output logic [7:0]                       ram_wdata,
  output logic                             ram_re,
  output logic [$clog2(CAPACITY)-1:0]      ram_raddr,
  input  wire logic [7:0]                  ram_rdata
);

  import olad_pkg::*;

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int CPW = CW + 8;

  state_t          state, state_next;
  logic [CW-1:0]   count, count_next;
  logic [AW-1:0]   idx, idx_next;

  logic            accept;
  logic            full;
  logic            empty;
  logic            pos_bad;
  logic            pos_at_end;
  logic            idx_last;
  logic [CPW-1:0]  pos_w;
  logic [CPW-1:0]  cnt_w;

  assign req_ready  = (state == ST_IDLE) && res_ready;
  assign accept     = req_valid && req_ready;
  assign full       = (count == CW'(CAPACITY));
  assign empty      = (count == '0);
  assign pos_w      = CPW'(position);
  assign cnt_w      = CPW'(count);
  assign pos_bad    = (position == 8'd0) || (pos_w > cnt_w);
  assign pos_at_end = (pos_w == cnt_w);
  assign idx_last   = ((CW'(idx) + CW'(1)) == count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_APPEND: begin
              if (!full) begin
                count_next = count + CW'(1);
              end
            end
            OP_DELETE: begin
              if (!empty && !pos_bad) begin
                if (pos_at_end) begin
                  count_next = count - CW'(1);
                end else begin
                  // entry after the deleted one, at address position, is the next one to move down
                  idx_next   = AW'(position);
                  state_next = ST_SHIFT;
                end
              end
            end
            OP_READ: begin
              if (!empty) begin
                idx_next   = '0;
                state_next = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SHIFT: begin
        if (idx_last) begin
          state_next = ST_DEL_DONE;
        end else begin
          idx_next = idx + AW'(1);
        end
      end
      ST_DEL_DONE: begin
        if (res_ready) begin
          count_next = count - CW'(1);
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        if (res_ready) begin
          if (idx_last) begin
            state_next = ST_IDLE;
          end else begin
            idx_next = idx + AW'(1);
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we          = 1'b0;
    ram_waddr       = count[AW-1:0];
    ram_wdata       = value;
    ram_re          = 1'b0;
    ram_raddr       = '0;
    res_valid       = 1'b0;
    res.status      = STATUS_OK;
    res.entry_value = '0;
    res.entry_index = '0;
    res.length      = 5'(count);
    res.last        = 1'b1;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_APPEND: begin
              res_valid = 1'b1;
              if (full) begin
                res.status = STATUS_FULL;
              end else begin
                ram_we     = 1'b1;
                res.length = 5'(count + CW'(1));
              end
            end
            OP_DELETE: begin
              if (empty) begin
                res_valid  = 1'b1;
                res.status = STATUS_EMPTY;
              end else if (pos_bad) begin
                res_valid  = 1'b1;
                res.status = STATUS_RANGE;
              end else if (pos_at_end) begin
                res_valid  = 1'b1;
                res.length = 5'(count - CW'(1));
              end else begin
                ram_re    = 1'b1;
                ram_raddr = AW'(position);
              end
            end
            OP_READ: begin
              if (empty) begin
                res_valid  = 1'b1;
                res.status = STATUS_EMPTY;
              end else begin
                ram_re = 1'b1;
              end
            end
            default: res_valid = 1'b1;
          endcase
        end
      end
      ST_SHIFT: begin
        // move entry idx down one slot while fetching idx+1, unless idx is the last entry
        ram_we    = 1'b1;
        ram_waddr = idx - AW'(1);
        ram_wdata = ram_rdata;
        if (!idx_last) begin
          ram_re    = 1'b1;
          ram_raddr = idx + AW'(1);
        end
      end
      ST_DEL_DONE: begin
        res_valid  = 1'b1;
        res.length = 5'(count - CW'(1));
      end
      ST_READ: begin
        res_valid       = 1'b1;
        res.entry_value = ram_rdata;
        res.entry_index = 5'(CW'(idx) + CW'(1));
        res.last        = idx_last;
        // hold read data until the transfer, then fetch the next entry
        if (res_ready && !idx_last) begin
          ram_re    = 1'b1;
          ram_raddr = idx + AW'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[rtl/ordered_list_append_delete_top.sv]
// Ordered list of up to CAPACITY bytes held in one single-port-write, registered-read
// RAM. Append, delete of the last entry, out-of-range or empty cases and the unused
// op code are answered from the idle state and pass through the output register.
// Deleting position p from a list of n entries moves the n-p later entries down one
// slot, one per cycle through the RAM, before the next request is taken. Read-out of
// n entries begins with a registered RAM read and then streams one entry per cycle
// while the consumer accepts them; the last entry carries last=1. Only one request
// is in progress at a time. The RAM needs no clearing after reset: only entries
// below the current length are ever read.
`default_nettype none

module ordered_list_append_delete_top #(
  parameter int CAPACITY = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_ready,
  input  wire logic [1:0] op,
  input  wire logic [7:0] value,
  input  wire logic [7:0] position,
  output logic            rsp_valid,
  input  wire logic       rsp_ready,
  output logic [1:0]      status,
  output logic [7:0]      entry_value,
  output logic [4:0]      entry_index,
  output logic [4:0]      length,
  output logic            last
);

  import olad_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  logic           res_valid;
  logic           res_ready;
  result_t        res;
  result_t        out_item;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [7:0]     ram_wdata;
  logic           ram_re;
  logic [AW-1:0]  ram_raddr;
  logic [7:0]     ram_rdata;

  olad_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .op        (op),
    .value     (value),
    .position  (position),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  olad_ram #(
    .WIDTH (8),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register: take a new result when empty or being drained
  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_item <= res;
    end
  end

  assign status      = out_item.status;
  assign entry_value = out_item.entry_value;
  assign entry_index = out_item.entry_index;
  assign length      = out_item.length;
  assign last        = out_item.last;

endmodule

`default_nettype wire

[rtl/olad_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module olad_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       req_valid,
  input wire logic       req_ready,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic [1:0] status,
  input wire logic [7:0] entry_value,
  input wire logic [4:0] entry_index,
  input wire logic [4:0] length,
  input wire logic       last
);

  import olad_pkg::*;

  logic        stalled;
  logic [20:0] payload;
  logic        err_rsp;
  logic        lone_rsp;
  logic        req_xfer;

  assign stalled  = rsp_valid && !rsp_ready;
  assign payload  = {status, entry_value, entry_index, length, last};
  assign err_rsp  = rsp_valid && (status != STATUS_OK);
  assign lone_rsp = last && (entry_index == 5'd0) && (entry_value == 8'd0);
  assign req_xfer = req_valid && req_ready;

  `OLAD_ASSERT_NEXT(a_rsp_hold, clk, rst, stalled, rsp_valid && $stable(payload), "rsp not held")

  `OLAD_ASSERT(a_error_single, clk, rst, err_rsp |-> lone_rsp, "error result not lone")

  // a pending non-final read-out entry means the sequencer is still streaming
  `OLAD_ASSERT(a_readout_busy, clk, rst, (rsp_valid && !last) |-> !req_ready, "read-out not busy")

  `OLAD_ASSERT(a_accept_room, clk, rst, req_xfer |-> (!rsp_valid || rsp_ready), "no room")

endmodule

bind ordered_list_append_delete_top olad_checker u_olad_checker (.*);

`default_nettype wire
